[design/lepwm_pkg.sv]
package lepwm_pkg;

  typedef struct packed {
    logic       kind;
    logic [3:0] mode;
    logic [9:0] value;
  } in_item_t;

  typedef struct packed {
    logic [10:0] period;
    logic [10:0] duty;
  } out_item_t;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  localparam logic [3:0] MODE_OFF        = 4'd0;
  localparam logic [3:0] MODE_BREATHE    = 4'd1;
  localparam logic [3:0] MODE_FAST_BLINK = 4'd2;
  localparam logic [3:0] MODE_SLOW_BLINK = 4'd3;
  localparam logic [3:0] MODE_ON         = 4'd4;
  localparam logic [3:0] MODE_TOGGLE     = 4'd5;
  localparam logic [3:0] MODE_BRIGHTNESS = 4'd6;
  localparam logic [3:0] MODE_FADE_OUT   = 4'd7;
  localparam logic [3:0] MODE_FADE_IN    = 4'd8;
  localparam logic [3:0] MODE_RATE_BLINK = 4'd9;
  localparam logic [3:0] MODE_DBL_FLASH  = 4'd10;

  // Hardware limit of the ceiling register
  localparam int unsigned CEIL_MAX = 1023;

  // floor(x / 50) for x < 1024 as (x * 1311) >> 16
  localparam logic [10:0] DIV50_MUL   = 11'd1311;
  localparam int unsigned DIV50_SHIFT = 16;

  localparam logic [9:0]  DARK_OFFSET = 10'd10;

  localparam logic [6:0]  FAST_WRAP   = 7'd40;
  localparam logic [6:0]  FAST_ON     = 7'd20;
  localparam logic [6:0]  FLASH_WRAP  = 7'd100;
  localparam logic [6:0]  FLASH_END1  = 7'd10;
  localparam logic [6:0]  FLASH_BEG2  = 7'd20;
  localparam logic [6:0]  FLASH_END2  = 7'd30;
  localparam logic [6:0]  FLASH_BEG3  = 7'd40;

  localparam logic [10:0] BLINK_SAT   = 11'd2047;

endpackage

[design/led_effect_pwm_sequencer_core.sv]
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-----------------------------
// in       | input     | in_valid / in_ready        | in_data  (kind, mode, value)
// out      | output    | out_valid / out_ready      | out_data (period, duty)
//
// One transaction per cycle sustained while out_ready stays high: an item is
// held in the input register, then the effect logic updates the channel state
// and, when the item causes a PWM write, loads the result register.
// A stalled result register holds the input register; in_ready then follows
// out_ready. Reset (rst, synchronous) restores steady-on mode, ceiling at full
// scale, and empties both registers.
module led_effect_pwm_sequencer_core #(
  parameter int unsigned FULL_SCALE = 100,
  parameter int unsigned MAX_VALUE  = 1023
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lepwm_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lepwm_pkg::out_item_t  out_data
);

  import lepwm_pkg::*;

  localparam int unsigned CeilLimInt = (MAX_VALUE > CEIL_MAX) ? CEIL_MAX : MAX_VALUE;
  localparam int unsigned FullInt    = (FULL_SCALE > CeilLimInt) ? CeilLimInt : FULL_SCALE;
  localparam logic [9:0]  CeilLim    = 10'(CeilLimInt);
  localparam logic [9:0]  FullVal    = 10'(FullInt);

  // Input and result registers
  logic      s_valid;
  in_item_t  s_item;
  logic      o_valid;
  out_item_t o_item;

  // Channel state
  logic [9:0]         ceiling;
  logic signed [11:0] breath_count;
  logic               breath_rising;
  logic [6:0]         pattern_count;
  logic [10:0]        blink_count;
  logic [3:0]         current_mode;
  logic [9:0]         level;
  logic [10:0]        last_duty;

  logic [9:0]         ceiling_next;
  logic signed [11:0] breath_count_next;
  logic               breath_rising_next;
  logic [6:0]         pattern_count_next;
  logic [10:0]        blink_count_next;
  logic [3:0]         current_mode_next;
  logic [9:0]         level_next;

  logic        fire;
  logic        produce;
  logic [10:0] res_period;
  logic [10:0] res_duty;

  logic [20:0] div_prod;
  logic [4:0]  ceil_div50;
  logic [10:0] period_std;
  logic [10:0] dark_duty;
  logic [10:0] toggle_duty;
  logic [9:0]  fade_sub;

  assign fire     = s_valid && (!o_valid || out_ready);
  assign in_ready = !s_valid || fire;

  assign out_valid = o_valid;
  assign out_data  = o_item;

  assign div_prod    = {11'd0, ceiling} * {10'd0, DIV50_MUL};
  assign ceil_div50  = div_prod[DIV50_SHIFT +: 5];
  assign period_std  = {1'b0, ceiling} + {6'd0, ceil_div50};
  assign dark_duty   = {1'b0, ceiling} + {1'b0, DARK_OFFSET};
  assign toggle_duty = (last_duty != 11'd0) ? 11'd0 : dark_duty;
  assign fade_sub    = (s_item.value > FullVal) ? FullVal : s_item.value;

  always_comb begin
    ceiling_next       = ceiling;
    breath_count_next  = breath_count;
    breath_rising_next = breath_rising;
    pattern_count_next = pattern_count;
    blink_count_next   = blink_count;
    current_mode_next  = current_mode;
    level_next         = level;
    produce            = 1'b0;
    res_period         = period_std;
    res_duty           = 11'd0;

    if (s_item.kind == KIND_CMD) begin
      current_mode_next = s_item.mode;
      level_next        = s_item.value;
      unique case (s_item.mode) inside
        MODE_OFF, MODE_FAST_BLINK, MODE_SLOW_BLINK, MODE_ON: begin
          ceiling_next = FullVal;
        end
        MODE_BREATHE: begin
          ceiling_next = (s_item.value > CeilLim) ? CeilLim : s_item.value;
        end
        MODE_TOGGLE: begin
          produce    = 1'b1;
          res_period = {1'b0, ceiling};
          res_duty   = toggle_duty;
        end
        MODE_BRIGHTNESS: begin
          produce  = 1'b1;
          res_duty = {1'b0, s_item.value};
        end
        MODE_FADE_OUT, MODE_FADE_IN: begin
          level_next = FullVal - fade_sub;
        end
        default: begin
        end
      endcase
    end else begin
      // Breathing runs on every tick, ahead of the mode effect
      if (breath_count < $signed({7'd0, ceil_div50})) breath_rising_next = 1'b1;
      if (breath_count > $signed({2'd0, ceiling}))    breath_rising_next = 1'b0;
      breath_count_next = breath_rising_next ? breath_count + 12'sd1
                                             : breath_count - 12'sd1;

      unique case (current_mode)
        MODE_OFF: begin
          produce  = 1'b1;
          res_duty = dark_duty;
        end
        MODE_BREATHE: begin
          produce  = 1'b1;
          res_duty = breath_count_next[11] ? 11'd0 : breath_count_next[10:0];
        end
        MODE_FAST_BLINK: begin
          pattern_count_next = (pattern_count > FAST_WRAP) ? 7'd0 : pattern_count + 7'd1;
          produce  = 1'b1;
          res_duty = (pattern_count_next > FAST_ON) ? {1'b0, ceiling} : 11'd0;
        end
        MODE_SLOW_BLINK: begin
          produce  = 1'b1;
          res_duty = breath_rising_next ? 11'd0 : {1'b0, ceiling};
        end
        MODE_ON: begin
          produce  = 1'b1;
          res_duty = 11'd0;
        end
        MODE_FADE_OUT: begin
          produce  = 1'b1;
          res_duty = {1'b0, level};
          if (level < FullVal) level_next = level + 10'd1;
        end
        MODE_FADE_IN: begin
          produce  = 1'b1;
          res_duty = {1'b0, level};
          if (level != 10'd0) level_next = level - 10'd1;
        end
        MODE_RATE_BLINK: begin
          if (blink_count >= {1'b0, level}) begin
            blink_count_next = 11'd0;
            produce          = 1'b1;
            res_period       = {1'b0, ceiling};
            res_duty         = toggle_duty;
          end else begin
            blink_count_next = (blink_count >= BLINK_SAT) ? BLINK_SAT : blink_count + 11'd1;
          end
        end
        MODE_DBL_FLASH: begin
          pattern_count_next = (pattern_count > FLASH_WRAP) ? 7'd0 : pattern_count + 7'd1;
          produce  = 1'b1;
          if ((pattern_count_next > 7'd0 && pattern_count_next < FLASH_END1) ||
              (pattern_count_next > FLASH_BEG2 && pattern_count_next < FLASH_END2) ||
              pattern_count_next > FLASH_BEG3) begin
            res_duty = {1'b0, ceiling};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid       <= 1'b0;
      o_valid       <= 1'b0;
      ceiling       <= FullVal;
      breath_count  <= 12'sd0;
      breath_rising <= 1'b0;
      pattern_count <= 7'd0;
      blink_count   <= 11'd0;
      current_mode  <= MODE_ON;
      level         <= 10'd0;
      last_duty     <= 11'd0;
    end else begin
      if (in_ready) begin
        s_valid <= in_valid;
      end
      if (fire) begin
        ceiling       <= ceiling_next;
        breath_count  <= breath_count_next;
        breath_rising <= breath_rising_next;
        pattern_count <= pattern_count_next;
        blink_count   <= blink_count_next;
        current_mode  <= current_mode_next;
        level         <= level_next;
        if (produce) begin
          last_duty <= res_duty;
        end
      end
      // Drop a taken result unless a new one replaces it
      if (fire && produce) begin
        o_valid <= 1'b1;
      end else if (out_ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_item <= in_data;
    end
    if (fire && produce) begin
      o_item.period <= res_period;
      o_item.duty   <= res_duty;
    end
  end

  a_last_duty_follows: assert property (@(posedge clk) disable iff (rst)
    (fire && produce) |=> (out_valid && last_duty == out_data.duty))
    else $error("last_duty does not match the written duty");

  a_ceiling_limit: assert property (@(posedge clk) disable iff (rst)
    ceiling <= CeilLim)
    else $error("ceiling above its clamp");

  a_pattern_range: assert property (@(posedge clk) disable iff (rst)
    pattern_count <= FLASH_WRAP + 7'd1)
    else $error("pattern counter out of range");

  a_breath_range: assert property (@(posedge clk) disable iff (rst)
    (breath_count >= -12'sd1) && (breath_count <= 12'sd1024))
    else $error("breathing counter out of range");

endmodule

[tb/led_effect_pwm_sequencer_core_tb.sv]
module led_effect_pwm_sequencer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lepwm_pkg::*;

  localparam int unsigned FULL        = 100;
  localparam int unsigned DARK        = 10;
  localparam logic [6:0]  FAST_LAST   = 7'd40;
  localparam logic [6:0]  FAST_LIT    = 7'd20;
  localparam logic [6:0]  FLASH_LAST  = 7'd100;
  localparam logic [10:0] BLINK_TOP   = 11'd2047;
  localparam logic [3:0]  MODE_SPARE  = 4'd11;
  localparam logic [3:0]  MODE_TOP    = 4'd15;
  localparam int          CYCLE_LIMIT = 200000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  led_effect_pwm_sequencer_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Channel state as the predictor sees it
  logic [9:0]  ch_ceiling;
  int          ch_breath;
  logic        ch_rising;
  logic [6:0]  ch_pattern;
  logic [10:0] ch_blink;
  logic [3:0]  ch_mode;
  logic [9:0]  ch_level;
  logic [10:0] ch_last_duty;

  out_item_t pwm_writes_due[$];
  out_item_t due_write;
  int        mismatch_count;
  int        items_sent;
  int        cycle_count;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_request;

  function automatic void clear_channel();
    ch_ceiling   = 10'(FULL);
    ch_breath    = 0;
    ch_rising    = 1'b0;
    ch_pattern   = '0;
    ch_blink     = '0;
    ch_mode      = MODE_ON;
    ch_level     = '0;
    ch_last_duty = '0;
  endfunction

  function automatic out_item_t toggle_write();
    out_item_t w;
    w.period = {1'b0, ch_ceiling};
    w.duty   = (ch_last_duty != 11'd0) ? 11'd0 : 11'(ch_ceiling + DARK);
    return w;
  endfunction

  // Apply one transaction to the channel state; return 1 when it writes the PWM register.
  function automatic bit next_pwm_write(input in_item_t it, output out_item_t w);
    int         per;
    bit         hit;
    logic [10:0] old_blink;
    per = int'(ch_ceiling) * 51 / 50;
    w   = '0;
    hit = 1'b1;
    if (it.kind == KIND_CMD) begin
      ch_mode  = it.mode;
      ch_level = it.value;
      hit      = 1'b0;
      case (it.mode)
        MODE_OFF, MODE_FAST_BLINK, MODE_SLOW_BLINK, MODE_ON: ch_ceiling = 10'(FULL);
        MODE_BREATHE: ch_ceiling = it.value;
        MODE_TOGGLE: begin
          w   = toggle_write();
          hit = 1'b1;
        end
        MODE_BRIGHTNESS: begin
          w.period = 11'(per);
          w.duty   = {1'b0, it.value};
          hit      = 1'b1;
        end
        MODE_FADE_OUT, MODE_FADE_IN: begin
          ch_level = (it.value > FULL) ? 10'd0 : 10'(FULL - it.value);
        end
        default: ;
      endcase
    end else begin
      if (ch_breath < int'(ch_ceiling) / 50) ch_rising = 1'b1;
      if (ch_breath > int'(ch_ceiling)) ch_rising = 1'b0;
      ch_breath += ch_rising ? 1 : -1;
      w.period = 11'(per);
      case (ch_mode)
        MODE_OFF: w.duty = 11'(ch_ceiling + DARK);
        MODE_BREATHE: w.duty = (ch_breath < 0) ? 11'd0 : 11'(ch_breath);
        MODE_FAST_BLINK: begin
          ch_pattern = (ch_pattern > FAST_LAST) ? 7'd0 : ch_pattern + 7'd1;
          w.duty = (ch_pattern > FAST_LIT) ? {1'b0, ch_ceiling} : 11'd0;
        end
        MODE_SLOW_BLINK: w.duty = ch_rising ? 11'd0 : {1'b0, ch_ceiling};
        MODE_ON: w.duty = 11'd0;
        MODE_FADE_OUT: begin
          w.duty = {1'b0, ch_level};
          if (ch_level < FULL) ch_level++;
        end
        MODE_FADE_IN: begin
          w.duty = {1'b0, ch_level};
          if (ch_level > 10'd0) ch_level--;
        end
        MODE_RATE_BLINK: begin
          old_blink = ch_blink;
          ch_blink  = (old_blink >= BLINK_TOP) ? BLINK_TOP : old_blink + 11'd1;
          hit       = (old_blink >= {1'b0, ch_level});
          if (hit) begin
            ch_blink = '0;
            w        = toggle_write();
          end
        end
        MODE_DBL_FLASH: begin
          ch_pattern = (ch_pattern > FLASH_LAST) ? 7'd0 : ch_pattern + 7'd1;
          // three lit windows: 1..9, 21..29, then everything past 40
          if ((ch_pattern > 7'd0 && ch_pattern < 7'd10) ||
              (ch_pattern > 7'd20 && ch_pattern < 7'd30) || ch_pattern > 7'd40)
            w.duty = {1'b0, ch_ceiling};
          else
            w.duty = 11'd0;
        end
        default: hit = 1'b0;
      endcase
    end
    if (hit) ch_last_duty = w.duty;
    return hit;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic send_item(input in_item_t it);
    out_item_t w;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (next_pwm_write(it, w)) pwm_writes_due.push_back(w);
    items_sent++;
  endtask

  task automatic send_cmd(input logic [3:0] mode, input logic [9:0] value);
    in_item_t it;
    it.kind  = KIND_CMD;
    it.mode  = mode;
    it.value = value;
    send_item(it);
  endtask

  // Ticks carry random mode and value bits, which the block must ignore.
  task automatic send_ticks(input int n);
    in_item_t it;
    repeat (n) begin
      it.kind  = KIND_TICK;
      it.mode  = 4'($urandom_range(MODE_TOP));
      it.value = 10'($urandom());
      send_item(it);
    end
  endtask

  function automatic logic [9:0] pick_value();
    case ($urandom_range(9))
      0:       return 10'd0;
      1:       return 10'd1023;
      2:       return 10'($urandom_range(1023));
      3, 4, 5: return 10'($urandom_range(60));
      default: return 10'($urandom_range(150));
    endcase
  endfunction

  function automatic logic [3:0] pick_mode();
    if ($urandom_range(9) == 0) return 4'($urandom_range(MODE_TOP, MODE_SPARE));
    return 4'($urandom_range(MODE_DBL_FLASH));
  endfunction

  task automatic test_each_mode();
    send_ticks(1);
    send_cmd(MODE_TOGGLE, 10'd0);
    send_cmd(MODE_TOGGLE, 10'd1023);
    send_cmd(MODE_OFF, 10'd1023);
    send_ticks(1);
    // zero ceiling walks the breathing count below zero
    send_cmd(MODE_BREATHE, 10'd0);
    send_ticks(4);
    send_cmd(MODE_BREATHE, 10'd1023);
    send_ticks(1);
    send_cmd(MODE_FAST_BLINK, 10'd0);
    send_ticks(1);
    send_cmd(MODE_SLOW_BLINK, 10'd1023);
    send_ticks(1);
    send_cmd(MODE_BRIGHTNESS, 10'd1023);
    send_cmd(MODE_BRIGHTNESS, 10'd0);
    send_cmd(MODE_FADE_OUT, 10'd1023);
    send_ticks(1);
    send_cmd(MODE_FADE_IN, 10'd0);
    send_ticks(1);
    send_cmd(MODE_RATE_BLINK, 10'd0);
    send_ticks(1);
    send_cmd(MODE_DBL_FLASH, 10'd512);
    send_ticks(1);
    send_cmd(MODE_TOP, 10'd1023);
    send_ticks(1);
  endtask

  task automatic test_breathing();
    repeat (8) begin
      send_cmd(MODE_BREATHE, 10'($urandom_range(80)));
      send_ticks($urandom_range(20, 40));
    end
    // high ceiling, then drop it far below the running count
    send_cmd(MODE_BREATHE, 10'd1023);
    send_ticks(40);
    send_cmd(MODE_BREATHE, 10'd5);
    send_ticks(45);
  endtask

  task automatic test_blink_patterns();
    send_cmd(MODE_DBL_FLASH, pick_value());
    send_ticks(150);
    // pattern count carries over from the double-flash run into fast blink
    send_cmd(MODE_FAST_BLINK, pick_value());
    send_ticks(90);
    send_cmd(MODE_SLOW_BLINK, pick_value());
    send_ticks(60);
  endtask

  task automatic test_fades_and_rate_blink();
    send_cmd(MODE_FADE_OUT, 10'd1023);
    send_ticks(105);
    send_cmd(MODE_FADE_IN, 10'd0);
    send_ticks(105);
    repeat (6) begin
      send_cmd(MODE_RATE_BLINK, 10'($urandom_range(12)));
      send_ticks(30);
      if ($urandom_range(1)) send_cmd(MODE_TOGGLE, pick_value());
    end
  endtask

  task automatic test_input_stall();
    send_cmd(MODE_ON, pick_value());
    hold_request = 80;
    send_ticks(40);
  endtask

  task automatic test_mixed_random(input int n);
    int       stop_at;
    in_item_t it;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(7) == 0) begin
        it = in_item_t'(15'($urandom()));
        send_item(it);
      end else begin
        send_cmd(pick_mode(), pick_value());
        send_ticks($urandom_range(1, 25));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, plus a long hold when one is requested.
  initial begin : drain
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pwm_writes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected write period %0d duty %0d",
                                  out_data.period, out_data.duty));
      end else begin
        due_write = pwm_writes_due.pop_front();
        if (out_data.period !== due_write.period)
          report_mismatch($sformatf("period %0d, expected %0d",
                                    out_data.period, due_write.period));
        if (out_data.duty !== due_write.duty)
          report_mismatch($sformatf("duty %0d, expected %0d",
                                    out_data.duty, due_write.duty));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("led_effect_pwm_sequencer_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    mismatch_count = 0;
    items_sent     = 0;
    cycle_count    = 0;
    hold_request   = 0;
    send_idle_pct  = 24;
    recv_idle_pct  = 48;
    clear_channel();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_each_mode();
    test_breathing();
    test_mixed_random(200);

    send_idle_pct = 48;
    recv_idle_pct = 24;
    test_blink_patterns();
    test_fades_and_rate_blink();
    test_mixed_random(200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_input_stall();
    test_mixed_random(200);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pwm_writes_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("led_effect_pwm_sequencer_core_tb OK");
    else
      $display("led_effect_pwm_sequencer_core_tb NOT OK");
    $finish;
  end

endmodule

[sim.f]
design/lepwm_pkg.sv
design/led_effect_pwm_sequencer_core.sv
tb/led_effect_pwm_sequencer_core_tb.sv
